### hdl/sjtm_pkg.sv
// Shared types, constants and helpers for the sorted junction table merge core.
// No dependencies; every other file in hdl/ except sjtm_ram imports this package.
package sjtm_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int REF_W    = 16;
    localparam int POS_W    = 31;
    localparam int STRAND_W = 2;
    localparam int MOTIF_W  = 3;
    localparam int COUNT_W  = 32;
    localparam int RIDX_W   = 10;
    localparam int SLOT_W   = 10;
    localparam int USED_W   = 11;

    localparam logic [STRAND_W-1:0] STRAND_UNDEF = '0;

    typedef enum logic {
        MODE_INSERT = 1'b0,
        MODE_READ   = 1'b1
    } mode_t;

    typedef struct packed {
        logic [REF_W-1:0]    ref_id;
        logic [POS_W-1:0]    donor;
        logic [POS_W-1:0]    acceptor;
        logic [STRAND_W-1:0] strand;
        logic [MOTIF_W-1:0]  motif;
        logic [COUNT_W-1:0]  uniq;
        logic [COUNT_W-1:0]  multi;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        mode_t               mode;
        logic [REF_W-1:0]    ref_id;
        logic [POS_W-1:0]    donor;
        logic [POS_W-1:0]    acceptor;
        logic [STRAND_W-1:0] strand;
        logic [MOTIF_W-1:0]  motif;
        logic                uniq;
        logic                multi;
        logic [RIDX_W-1:0]   read_index;
    } item_t;

    // result of the shared key compare: stored entry versus item key
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_t;

    typedef struct packed {
        logic              hit;
        logic              dropped;
        logic [SLOT_W-1:0] slot;
        logic [USED_W-1:0] entries_used;
        entry_t            ent;
    } result_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_MISS,
        ST_SHIFT_PRIME,
        ST_SHIFT,
        ST_WRITE,
        ST_MERGE,
        ST_READ,
        ST_DONE
    } state_t;

endpackage

### hdl/sorted_junction_table_merge_core.sv
// Sorted junction table merge core: one item in, one result beat out.
// Only one item is in flight at a time. An insert compares entries from the top of the table
// and, on a miss, shifts the entries above the insert slot up, all through the single read
// and write port of the entry RAM. The next item is taken in the cycle after the result
// moves to the output register. Reset clears the fill count only; no clearing pass.
module sorted_junction_table_merge_core
    import sjtm_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // ref_id[15:0], donor_pos[46:16], acceptor_pos[77:47], strand_code[79:78],
    // motif_code[82:80], unique_reads[83], multi_reads[84], read_index[94:85], pad[95]
    input  logic [95:0]  s_tdata,
    // mode[0]
    input  logic         s_tuser,
    // last_in_read, no effect on the table
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // slot[9:0], entries_used[20:10], out_ref_id[36:21], out_donor[67:37],
    // out_acceptor[98:68], out_strand[100:99], out_motif[103:101],
    // out_unique[135:104], out_multi[167:136]
    output logic [167:0] m_tdata,
    // hit[0], dropped[1]
    output logic [1:0]   m_tuser
);

    item_t   in_item;
    result_t res;
    logic    res_valid;
    logic    res_take;
    logic    m_valid_reg;
    result_t out_reg;

    always_comb begin
        in_item            = '0;
        in_item.mode       = mode_t'(s_tuser);
        in_item.ref_id     = s_tdata[15:0];
        in_item.donor      = s_tdata[46:16];
        in_item.acceptor   = s_tdata[77:47];
        in_item.strand     = s_tdata[79:78];
        in_item.motif      = s_tdata[82:80];
        in_item.uniq       = s_tdata[83];
        in_item.multi      = s_tdata[84];
        in_item.read_index = s_tdata[94:85];
    end

    sjtm_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (in_item),
        .res_valid(res_valid),
        .res_take (res_take),
        .res      (res)
    );

    // output beat register; free when empty or being taken
    assign res_take = res_valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = {out_reg.dropped, out_reg.hit};
    assign m_tdata  = {out_reg.ent.multi, out_reg.ent.uniq, out_reg.ent.motif,
                       out_reg.ent.strand, out_reg.ent.acceptor, out_reg.ent.donor,
                       out_reg.ent.ref_id, out_reg.entries_used, out_reg.slot};

endmodule

### hdl/sjtm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sjtm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hdl/sjtm_unit.sv
// Shared key compare and merge unit: lexicographic compare of a stored entry
// against the item key, and the merge: saturating counts, strand cleared on a mismatch. Depends on sjtm_pkg.
module sjtm_unit
    import sjtm_pkg::*;
(
    input  entry_t ent,
    input  item_t  item,
    output cmp_t   cmp,
    output entry_t merged
);

    logic [2*POS_W+REF_W-1:0] ent_key;
    logic [2*POS_W+REF_W-1:0] item_key;
    logic [COUNT_W:0]         uniq_sum;
    logic [COUNT_W:0]         multi_sum;

    // concatenated key compares in (ref, donor, acceptor) order
    assign ent_key  = {ent.ref_id, ent.donor, ent.acceptor};
    assign item_key = {item.ref_id, item.donor, item.acceptor};
    assign cmp.eq   = (ent_key == item_key);
    assign cmp.lt   = (ent_key < item_key);

    assign uniq_sum  = {1'b0, ent.uniq} + {{COUNT_W{1'b0}}, item.uniq};
    assign multi_sum = {1'b0, ent.multi} + {{COUNT_W{1'b0}}, item.multi};

    always_comb begin
        merged        = ent;
        merged.uniq   = uniq_sum[COUNT_W] ? {COUNT_W{1'b1}} : uniq_sum[COUNT_W-1:0];
        merged.multi  = multi_sum[COUNT_W] ? {COUNT_W{1'b1}} : multi_sum[COUNT_W-1:0];
        merged.strand = (ent.strand != item.strand) ? STRAND_UNDEF : ent.strand;
    end

endmodule

### hdl/sjtm_seq.sv
// Sequencer: scan from the top of the table, shift on a miss, merge on a hit,
// or read one entry. Depends on sjtm_pkg, sjtm_ram and sjtm_unit.
module sjtm_seq
    import sjtm_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    in_valid,
    output logic    in_ready,
    input  item_t   in_item,
    output logic    res_valid,
    input  logic    res_take,
    output result_t res
);

    state_t            state_reg, state_next;
    item_t             item_reg, item_next;
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  pos_reg, pos_next;
    entry_t            hold_reg, hold_next;
    result_t           res_reg, res_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    entry_t            ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    entry_t            rd_ent;
    cmp_t              cmp;
    entry_t            merged;
    entry_t            new_ent;
    logic              ridx_ok;
    logic [CNT_W-1:0]  idx_m1;
    logic [CNT_W-1:0]  idx_m2;
    logic [CNT_W-1:0]  fill_m1;

    sjtm_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign rd_ent = entry_t'(ram_rdata);

    sjtm_unit u_unit (
        .ent   (state_reg == ST_MERGE ? hold_reg : rd_ent),
        .item  (item_reg),
        .cmp   (cmp),
        .merged(merged)
    );

    assign idx_m1  = idx_reg - CNT_W'(1);
    assign idx_m2  = idx_reg - CNT_W'(2);
    assign fill_m1 = fill_reg - CNT_W'(1);
    assign ridx_ok = (32'(item_reg.read_index) < 32'(fill_reg));

    always_comb begin
        new_ent          = '0;
        new_ent.ref_id   = item_reg.ref_id;
        new_ent.donor    = item_reg.donor;
        new_ent.acceptor = item_reg.acceptor;
        new_ent.strand   = item_reg.strand;
        new_ent.motif    = item_reg.motif;
        new_ent.uniq     = {{(COUNT_W-1){1'b0}}, item_reg.uniq};
        new_ent.multi    = {{(COUNT_W-1){1'b0}}, item_reg.multi};
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (item_reg.mode == MODE_READ) begin
                    state_next = ridx_ok ? ST_READ : ST_DONE;
                end else if (fill_reg == '0) begin
                    state_next = ST_MISS;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cmp.eq) begin
                    state_next = ST_MERGE;
                end else if (cmp.lt || idx_reg == CNT_W'(1)) begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS: begin
                priority if (fill_reg == CNT_W'(TABLE_DEPTH)) begin
                    state_next = ST_DONE;
                end else if (pos_reg == fill_reg) begin
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_SHIFT_PRIME;
                end
            end
            ST_SHIFT_PRIME: state_next = ST_SHIFT;
            ST_SHIFT: begin
                if (idx_m1 == pos_reg) begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE: state_next = ST_DONE;
            ST_MERGE: state_next = ST_DONE;
            ST_READ:  state_next = ST_DONE;
            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        item_next = item_reg;
        fill_next = fill_reg;
        idx_next  = idx_reg;
        pos_next  = pos_reg;
        hold_next = hold_reg;
        res_next  = res_reg;
        ram_we    = 1'b0;
        ram_waddr = IDX_W'(idx_reg);
        ram_wdata = rd_ent;
        ram_raddr = IDX_W'(idx_m2);
        unique case (state_reg)
            ST_IDLE: begin
                item_next = in_item;
            end
            ST_START: begin
                res_next              = '0;
                res_next.slot         = SLOT_W'(item_reg.read_index);
                res_next.entries_used = USED_W'(fill_reg);
                if (item_reg.mode == MODE_READ) begin
                    ram_raddr = IDX_W'(item_reg.read_index);
                end else begin
                    ram_raddr = IDX_W'(fill_m1);
                    idx_next  = fill_reg;
                    pos_next  = '0;
                end
            end
            ST_SCAN: begin
                // read of the next lower entry goes out speculatively
                hold_next = rd_ent;
                if (cmp.eq) begin
                    pos_next = idx_m1;
                end else if (cmp.lt) begin
                    pos_next = idx_reg;
                end else if (idx_reg == CNT_W'(1)) begin
                    pos_next = '0;
                end else begin
                    idx_next = idx_m1;
                end
            end
            ST_MISS: begin
                res_next              = '0;
                res_next.dropped      = 1'b1;
                res_next.entries_used = USED_W'(fill_reg);
            end
            ST_SHIFT_PRIME: begin
                ram_raddr = IDX_W'(fill_m1);
                idx_next  = fill_reg;
            end
            ST_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = IDX_W'(idx_reg);
                ram_wdata = rd_ent;
                idx_next  = idx_m1;
            end
            ST_WRITE: begin
                ram_we                = 1'b1;
                ram_waddr             = IDX_W'(pos_reg);
                ram_wdata             = new_ent;
                fill_next             = fill_reg + CNT_W'(1);
                res_next.hit          = 1'b0;
                res_next.dropped      = 1'b0;
                res_next.slot         = SLOT_W'(pos_reg);
                res_next.entries_used = USED_W'(fill_reg + CNT_W'(1));
                res_next.ent          = new_ent;
            end
            ST_MERGE: begin
                ram_we                = 1'b1;
                ram_waddr             = IDX_W'(pos_reg);
                ram_wdata             = merged;
                res_next.hit          = 1'b1;
                res_next.dropped      = 1'b0;
                res_next.slot         = SLOT_W'(pos_reg);
                res_next.entries_used = USED_W'(fill_reg);
                res_next.ent          = merged;
            end
            ST_READ: begin
                res_next.ent = rd_ent;
            end
            ST_DONE: begin
                item_next = item_reg;
            end
            default: begin
                item_next = item_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
        end else begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        idx_reg  <= idx_next;
        pos_reg  <= pos_next;
        hold_reg <= hold_next;
        res_reg  <= res_next;
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

endmodule
